// ===== rtl/klr_pkg.sv =====
// ----------------------------------------------------------------------------
// klr_pkg
// Shared constants, types and the key clean-up function for the keyed lifo.
// ----------------------------------------------------------------------------
package klr_pkg;

    localparam int DEPTH = 16;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    localparam logic [1:0] OP_PUSH   = 2'd0;
    localparam logic [1:0] OP_POP    = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NULL    = 2'd1;
    localparam logic [1:0] ST_MISSING = 2'd2;
    localparam logic [1:0] ST_FULL    = 2'd3;

    typedef struct packed {
        logic [63:0] lo;
        logic [7:0]  hi;
    } t_key;

    // per-cell controls for one cycle
    typedef struct packed {
        logic cmp;
        logic load;
        logic shift;
    } t_cell_ctl;

    // bytes after the first zero byte do not belong to the key
    function automatic t_key norm_key(input logic [63:0] lo, input logic [7:0] hi);
        t_key k;
        logic ended;
        k.lo  = lo;
        k.hi  = hi;
        ended = 1'b0;
        for (int b = 0; b < 8; b++) begin
            if (ended) begin
                k.lo[8*b +: 8] = 8'h00;
            end else if (lo[8*b +: 8] == 8'h00) begin
                ended = 1'b1;
            end
        end
        if (ended) begin
            k.hi = 8'h00;
        end
        return k;
    endfunction

endpackage

// ===== rtl/keyed_lifo_with_removal_top.sv =====
// ----------------------------------------------------------------------------
// keyed_lifo_with_removal_top
// Last-in-first-out store of keyed entries with removal by key.
// ----------------------------------------------------------------------------
// Usage: drive i_operation, i_key_low, i_key_high and i_handle and raise
// start; the beat is taken on an edge where busy is low. Push puts an entry
// at the front, pop returns the front entry, remove returns the entry nearest
// the front whose key matches and closes the gap in the row of cells.
// Each beat gives exactly one result, shown for one cycle with o_valid high.
// Push, pop and unused codes go straight to the result step; remove first
// compares every occupied cell in parallel, then makes the priority pick of
// the nearest match, then shifts the cells above it down while the result
// is registered. The store takes no new beat until the current one is done;
// busy is high meanwhile.
// Reset empties the store at once (entry count to zero); cell contents are
// not cleared and are never read before they are written.
// The receiver cannot stall: a result must be taken in the cycle it is shown.
// ----------------------------------------------------------------------------
module keyed_lifo_with_removal_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_operation,
    input  logic [63:0] i_key_low,
    input  logic [7:0]  i_key_high,
    input  logic [15:0] i_handle,
    output logic        o_valid,
    output logic [1:0]  o_status,
    output logic [15:0] o_out_handle,
    output logic [63:0] o_out_key_low,
    output logic [7:0]  o_out_key_high
);
    import klr_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CMP  = 2'd1;
    localparam logic [1:0] S_SEL  = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0]       r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_valid, n_valid;

    logic [1:0]       r_op;
    t_key             r_key;
    logic [15:0]      r_handle;
    logic [IDX_W-1:0] r_rd_idx, n_rd_idx;
    logic [CNT_W-1:0] r_found, n_found;
    logic             r_hit, n_hit;
    logic [1:0]       r_status, n_status;
    t_key             r_out_key, n_out_key;
    logic [15:0]      r_out_handle, n_out_handle;

    t_key             in_key;
    logic             accept;
    logic             do_push, do_shift;

    t_cell_ctl        cell_ctl    [DEPTH];
    t_key             cell_key    [DEPTH];
    logic [15:0]      cell_handle [DEPTH];
    logic [DEPTH-1:0] cell_match;

    assign in_key = norm_key(i_key_low, i_key_high);
    assign accept = start && !busy;
    assign busy   = (r_state != S_IDLE);

    assign do_push  = (r_state == S_DONE) && (r_op == OP_PUSH) && (r_handle != 16'h0000)
                      && (r_count != CNT_W'(DEPTH));
    assign do_shift = (r_state == S_DONE) && (r_op == OP_REMOVE) && r_hit;

    // row of cells, each but the top one fed by the one above
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        assign cell_ctl[g].cmp   = (r_state == S_CMP) && (CNT_W'(g) < r_count);
        assign cell_ctl[g].load  = do_push && (CNT_W'(g) == r_count);
        assign cell_ctl[g].shift = do_shift && (CNT_W'(g) >= r_found)
                                   && (CNT_W'(g + 1) < r_count);
        if (g == DEPTH - 1) begin : g_top
            klr_cell u_cell (
                .i_clk       (i_clk),
                .i_ctl       (cell_ctl[g]),
                .i_key       (r_key),
                .i_handle    (r_handle),
                .i_up_key    (cell_key[g]),
                .i_up_handle (cell_handle[g]),
                .o_key       (cell_key[g]),
                .o_handle    (cell_handle[g]),
                .o_match     (cell_match[g])
            );
        end else begin : g_mid
            klr_cell u_cell (
                .i_clk       (i_clk),
                .i_ctl       (cell_ctl[g]),
                .i_key       (r_key),
                .i_handle    (r_handle),
                .i_up_key    (cell_key[g+1]),
                .i_up_handle (cell_handle[g+1]),
                .o_key       (cell_key[g]),
                .o_handle    (cell_handle[g]),
                .o_match     (cell_match[g])
            );
        end
    end

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_valid      = 1'b0;
        n_rd_idx     = r_rd_idx;
        n_found      = r_found;
        n_hit        = r_hit;
        n_status     = r_status;
        n_out_key    = r_out_key;
        n_out_handle = r_out_handle;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_rd_idx = IDX_W'(r_count - CNT_W'(1));
                    n_state  = (i_operation == OP_REMOVE) ? S_CMP : S_DONE;
                end
            end
            S_CMP: begin
                n_state = S_SEL;
            end
            S_SEL: begin
                // highest matching cell is nearest the front
                n_found = '0;
                n_hit   = 1'b0;
                for (int j = 0; j < DEPTH; j++) begin
                    if (cell_match[j]) begin
                        n_found = CNT_W'(j);
                        n_hit   = 1'b1;
                    end
                end
                n_rd_idx = IDX_W'(n_found);
                n_state  = S_DONE;
            end
            S_DONE: begin
                n_state      = S_IDLE;
                n_valid      = 1'b1;
                n_status     = ST_OK;
                n_out_key    = '0;
                n_out_handle = 16'h0000;
                unique case (r_op)
                    OP_PUSH: begin
                        if (r_handle == 16'h0000) begin
                            n_status = ST_NULL;
                        end else if (r_count == CNT_W'(DEPTH)) begin
                            n_status = ST_FULL;
                        end else begin
                            n_count = r_count + CNT_W'(1);
                        end
                    end
                    OP_POP: begin
                        if (r_count == '0) begin
                            n_status = ST_MISSING;
                        end else begin
                            n_out_key    = cell_key[r_rd_idx];
                            n_out_handle = cell_handle[r_rd_idx];
                            n_count      = r_count - CNT_W'(1);
                        end
                    end
                    OP_REMOVE: begin
                        if (!r_hit) begin
                            n_status = ST_MISSING;
                        end else begin
                            n_out_key    = cell_key[r_rd_idx];
                            n_out_handle = cell_handle[r_rd_idx];
                            n_count      = r_count - CNT_W'(1);
                        end
                    end
                    default: begin
                        n_status = ST_OK;
                    end
                endcase
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op     <= i_operation;
            r_key    <= in_key;
            r_handle <= i_handle;
        end
        r_rd_idx     <= n_rd_idx;
        r_found      <= n_found;
        r_hit        <= n_hit;
        r_status     <= n_status;
        r_out_key    <= n_out_key;
        r_out_handle <= n_out_handle;
    end

    assign o_valid        = r_valid;
    assign o_status       = r_status;
    assign o_out_handle   = r_out_handle;
    assign o_out_key_low  = r_out_key.lo;
    assign o_out_key_high = r_out_key.hi;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("entry count above depth");

    a_done_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |=> o_valid)
        else $error("finished beat gave no result");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted beat did not raise busy");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == ST_FULL)) |-> (r_count == CNT_W'(DEPTH)))
        else $error("full reported with room left");

endmodule

// ===== rtl/klr_cell.sv =====
// ----------------------------------------------------------------------------
// klr_cell
// One slot of the store: holds an entry, compares its key against the
// broadcast key, loads a new entry or takes the entry of the slot above.
// ----------------------------------------------------------------------------
module klr_cell (
    input  logic               i_clk,
    input  klr_pkg::t_cell_ctl i_ctl,
    input  klr_pkg::t_key      i_key,
    input  logic [15:0]        i_handle,
    input  klr_pkg::t_key      i_up_key,
    input  logic [15:0]        i_up_handle,
    output klr_pkg::t_key      o_key,
    output logic [15:0]        o_handle,
    output logic               o_match
);
    import klr_pkg::*;

    t_key        r_key;
    logic [15:0] r_handle;
    logic        r_match;

    always_ff @(posedge i_clk) begin
        r_match <= i_ctl.cmp && (r_key == i_key);
        if (i_ctl.load) begin
            r_key    <= i_key;
            r_handle <= i_handle;
        end else if (i_ctl.shift) begin
            r_key    <= i_up_key;
            r_handle <= i_up_handle;
        end
    end

    assign o_key    = r_key;
    assign o_handle = r_handle;
    assign o_match  = r_match;

endmodule
